### hdl/assert_macros.svh
// Assertion helpers used by the checker of this project.
// Both macros expect clk and arst_n to be visible where they are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define QVR_ASSERT_SAME(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Check a consequent in the cycle after its antecedent.
`define QVR_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### hdl/qvr_pkg.sv
`timescale 1ns / 1ps
package qvr_pkg;

	// Quaternion components are signed Q1.14 in 16 bits.
	localparam int QUAT_WIDTH = 16;
	// Squared norm: four squares of 16-bit values.
	localparam int NORM_WIDTH = 2 * QUAT_WIDTH + 1;
	// Vector lanes.
	localparam int LANES = 3;

	// Per-beat side information carried along the divider.
	typedef struct packed {
		logic             zero_norm;
		logic [LANES-1:0] neg;
	} qvr_flags_t;

endpackage

### hdl/qvr_front.sv
`timescale 1ns / 1ps
module qvr_front #(
	parameter int VEC_WIDTH = 16
) (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  logic                                           in_valid,
	output logic                                           in_ready,
	input  logic signed [qvr_pkg::QUAT_WIDTH-1:0]          quat_w,
	input  logic signed [qvr_pkg::QUAT_WIDTH-1:0]          quat_x,
	input  logic signed [qvr_pkg::QUAT_WIDTH-1:0]          quat_y,
	input  logic signed [qvr_pkg::QUAT_WIDTH-1:0]          quat_z,
	input  logic signed [VEC_WIDTH-1:0]                    vec_x,
	input  logic signed [VEC_WIDTH-1:0]                    vec_y,
	input  logic signed [VEC_WIDTH-1:0]                    vec_z,
	output logic                                           out_valid,
	input  logic                                           out_ready,
	output logic [VEC_WIDTH+2*qvr_pkg::QUAT_WIDTH+4:0]     num_x,
	output logic [VEC_WIDTH+2*qvr_pkg::QUAT_WIDTH+4:0]     num_y,
	output logic [VEC_WIDTH+2*qvr_pkg::QUAT_WIDTH+4:0]     num_z,
	output logic [qvr_pkg::NORM_WIDTH:0]                   den,
	output qvr_pkg::qvr_flags_t                            flags
);
	import qvr_pkg::*;

	localparam int PW = VEC_WIDTH + QUAT_WIDTH;  // vector times quaternion
	localparam int MW = PW + 2;                  // three-term sum
	localparam int TW = MW + QUAT_WIDTH;         // quaternion times m
	localparam int RW = TW + 2;                  // four-term sum
	localparam int NW = RW + 1;                  // 2*|r| + n

	logic [5:1] v, en;

	logic signed [QUAT_WIDTH-1:0] qw_s1, qx_s1, qy_s1, qz_s1;
	logic signed [PW-1:0]         p_s1 [12];
	logic [2*QUAT_WIDTH-1:0]      sq_s1 [4];

	logic signed [QUAT_WIDTH-1:0] qw_s2, qx_s2, qy_s2, qz_s2;
	logic signed [MW-1:0]         m_s2 [4];
	logic [NORM_WIDTH-1:0]        n_s2;

	logic signed [TW-1:0]         t_s3 [12];
	logic [NORM_WIDTH-1:0]        n_s3;

	logic signed [RW-1:0]         r_s4 [LANES];
	logic [NORM_WIDTH-1:0]        n_s4;

	logic [NW-1:0]                num_s5 [LANES];
	logic [NORM_WIDTH:0]          den_s5;
	qvr_flags_t                   flags_s5;

	logic [RW-1:0]                mag_c [LANES];
	logic [NW-1:0]                num_c [LANES];
	logic [LANES-1:0]             neg_c;

	// Advance a stage when it is empty or the next one advances.
	assign en[5]    = !v[5] || out_ready;
	assign en[4]    = !v[4] || en[5];
	assign en[3]    = !v[3] || en[4];
	assign en[2]    = !v[2] || en[3];
	assign en[1]    = !v[1] || en[2];
	assign in_ready = en[1];

	// Move valid bits along with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v <= '0;
		end else begin
			if (en[1]) v[1] <= in_valid;
			if (en[2]) v[2] <= v[1];
			if (en[3]) v[3] <= v[2];
			if (en[4]) v[4] <= v[3];
			if (en[5]) v[5] <= v[4];
		end
	end

	// Form the products of v with the quaternion, and the squares.
	always_ff @(posedge clk) begin
		if (en[1]) begin
			qw_s1    <= quat_w;
			qx_s1    <= quat_x;
			qy_s1    <= quat_y;
			qz_s1    <= quat_z;
			p_s1[0]  <= vec_x * quat_x;
			p_s1[1]  <= vec_y * quat_y;
			p_s1[2]  <= vec_z * quat_z;
			p_s1[3]  <= vec_x * quat_w;
			p_s1[4]  <= vec_y * quat_z;
			p_s1[5]  <= vec_z * quat_y;
			p_s1[6]  <= vec_x * quat_z;
			p_s1[7]  <= vec_y * quat_w;
			p_s1[8]  <= vec_z * quat_x;
			p_s1[9]  <= vec_x * quat_y;
			p_s1[10] <= vec_y * quat_x;
			p_s1[11] <= vec_z * quat_w;
			sq_s1[0] <= quat_w * quat_w;
			sq_s1[1] <= quat_x * quat_x;
			sq_s1[2] <= quat_y * quat_y;
			sq_s1[3] <= quat_z * quat_z;
		end
	end

	// Sum into m = (0, v) * conj(q) and the squared norm.
	always_ff @(posedge clk) begin
		if (en[2]) begin
			qw_s2   <= qw_s1;
			qx_s2   <= qx_s1;
			qy_s2   <= qy_s1;
			qz_s2   <= qz_s1;
			m_s2[0] <= MW'(p_s1[0]) + MW'(p_s1[1]) + MW'(p_s1[2]);
			m_s2[1] <= MW'(p_s1[3]) - MW'(p_s1[4]) + MW'(p_s1[5]);
			m_s2[2] <= MW'(p_s1[6]) + MW'(p_s1[7]) - MW'(p_s1[8]);
			m_s2[3] <= MW'(p_s1[10]) + MW'(p_s1[11]) - MW'(p_s1[9]);
			n_s2    <= NORM_WIDTH'(sq_s1[0]) + NORM_WIDTH'(sq_s1[1])
				+ NORM_WIDTH'(sq_s1[2]) + NORM_WIDTH'(sq_s1[3]);
		end
	end

	// Multiply m on the left by q.
	always_ff @(posedge clk) begin
		if (en[3]) begin
			t_s3[0]  <= qw_s2 * m_s2[1];
			t_s3[1]  <= qx_s2 * m_s2[0];
			t_s3[2]  <= qy_s2 * m_s2[3];
			t_s3[3]  <= qz_s2 * m_s2[2];
			t_s3[4]  <= qw_s2 * m_s2[2];
			t_s3[5]  <= qx_s2 * m_s2[3];
			t_s3[6]  <= qy_s2 * m_s2[0];
			t_s3[7]  <= qz_s2 * m_s2[1];
			t_s3[8]  <= qw_s2 * m_s2[3];
			t_s3[9]  <= qx_s2 * m_s2[2];
			t_s3[10] <= qy_s2 * m_s2[1];
			t_s3[11] <= qz_s2 * m_s2[0];
			n_s3     <= n_s2;
		end
	end

	// Sum the vector part of q * m.
	always_ff @(posedge clk) begin
		if (en[4]) begin
			r_s4[0] <= RW'(t_s3[0]) + RW'(t_s3[1]) + RW'(t_s3[2]) - RW'(t_s3[3]);
			r_s4[1] <= RW'(t_s3[4]) - RW'(t_s3[5]) + RW'(t_s3[6]) + RW'(t_s3[7]);
			r_s4[2] <= RW'(t_s3[8]) + RW'(t_s3[9]) - RW'(t_s3[10]) + RW'(t_s3[11]);
			n_s4    <= n_s3;
		end
	end

	// Fold rounding into the dividend: q = floor((2|r| + n) / 2n).
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			neg_c[l] = r_s4[l][RW-1];
			mag_c[l] = neg_c[l] ? RW'(-r_s4[l]) : RW'(r_s4[l]);
			num_c[l] = (NW'(mag_c[l]) << 1) + NW'(n_s4);
		end
	end

	always_ff @(posedge clk) begin
		if (en[5]) begin
			for (int l = 0; l < LANES; l++) begin
				num_s5[l] <= num_c[l];
			end
			den_s5             <= {n_s4, 1'b0};
			flags_s5.zero_norm <= (n_s4 == '0);
			flags_s5.neg       <= neg_c;
		end
	end

	assign out_valid = v[5];
	assign num_x     = num_s5[0];
	assign num_y     = num_s5[1];
	assign num_z     = num_s5[2];
	assign den       = den_s5;
	assign flags     = flags_s5;

endmodule

### hdl/qvr_div.sv
`timescale 1ns / 1ps
module qvr_div #(
	parameter int VEC_WIDTH = 16
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       in_valid,
	output logic                                       in_ready,
	input  logic [VEC_WIDTH+2*qvr_pkg::QUAT_WIDTH+4:0] num_x,
	input  logic [VEC_WIDTH+2*qvr_pkg::QUAT_WIDTH+4:0] num_y,
	input  logic [VEC_WIDTH+2*qvr_pkg::QUAT_WIDTH+4:0] num_z,
	input  logic [qvr_pkg::NORM_WIDTH:0]               den,
	input  qvr_pkg::qvr_flags_t                        flags,
	output logic                                       out_valid,
	input  logic                                       out_ready,
	output logic signed [VEC_WIDTH-1:0]                rotated_x,
	output logic signed [VEC_WIDTH-1:0]                rotated_y,
	output logic signed [VEC_WIDTH-1:0]                rotated_z,
	output logic                                       zero_norm,
	output logic                                       saturated
);
	import qvr_pkg::*;

	localparam int NW = VEC_WIDTH + 2 * QUAT_WIDTH + 5;
	localparam int K  = VEC_WIDTH + 1;   // quotient bits
	localparam int S  = K + 2;           // range check, K steps, output

	logic [S-1:0] v, en;

	// Stage 0 checks range, stage j in 1..K resolves quotient bit K-j.
	logic [NW-1:0]        rem_s  [K+1][LANES];
	logic [K-1:0]         quot_s [K+1][LANES];
	logic [LANES-1:0]     ovf_s  [K+1];
	logic [NORM_WIDTH:0]  den_s  [K+1];
	qvr_flags_t           flg_s  [K+1];

	logic [NW-1:0]        rem_c  [K+1][LANES];
	logic [K-1:0]         quot_c [K+1][LANES];
	logic [NW-1:0]        sh_c   [K+1];

	logic signed [VEC_WIDTH-1:0] res_s [LANES];
	logic                 zn_s, sat_s;

	logic [K-1:0]         lim_c  [LANES];
	logic [K-1:0]         qv_c   [LANES];
	logic [K-1:0]         sv_c   [LANES];
	logic [LANES-1:0]     lsat_c;

	// Advance a stage when it is empty or the next one advances.
	always_comb begin
		en[S-1] = !v[S-1] || out_ready;
		for (int j = S - 2; j >= 0; j--) begin
			en[j] = !v[j] || en[j+1];
		end
	end
	assign in_ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v <= '0;
		end else begin
			if (en[0]) v[0] <= in_valid;
			for (int j = 1; j < S; j++) begin
				if (en[j]) v[j] <= v[j-1];
			end
		end
	end

	// One restoring step in each of stages 1..K on each lane.
	always_comb begin
		sh_c[0]      = NW'(den) << K;
		rem_c[0][0]  = num_x;
		rem_c[0][1]  = num_y;
		rem_c[0][2]  = num_z;
		for (int l = 0; l < LANES; l++) begin
			quot_c[0][l] = '0;
		end
		for (int j = 1; j <= K; j++) begin
			sh_c[j] = NW'(den_s[j-1]) << (K - j);
			for (int l = 0; l < LANES; l++) begin
				rem_c[j][l]  = rem_s[j-1][l];
				quot_c[j][l] = quot_s[j-1][l];
				if (rem_s[j-1][l] >= sh_c[j]) begin
					rem_c[j][l]  = rem_s[j-1][l] - sh_c[j];
					quot_c[j][l] = quot_s[j-1][l] | (K'(1) << (K - j));
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int l = 0; l < LANES; l++) begin
				rem_s[0][l]  <= rem_c[0][l];
				quot_s[0][l] <= quot_c[0][l];
				ovf_s[0][l]  <= rem_c[0][l] >= sh_c[0];
			end
			den_s[0] <= den;
			flg_s[0] <= flags;
		end
		for (int j = 1; j <= K; j++) begin
			if (en[j]) begin
				for (int l = 0; l < LANES; l++) begin
					rem_s[j][l]  <= rem_c[j][l];
					quot_s[j][l] <= quot_c[j][l];
				end
				ovf_s[j] <= ovf_s[j-1];
				den_s[j] <= den_s[j-1];
				flg_s[j] <= flg_s[j-1];
			end
		end
	end

	// Clip to the signed range and apply the sign.
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			lim_c[l]  = flg_s[K].neg[l] ? (K'(1) << (VEC_WIDTH - 1))
				: ((K'(1) << (VEC_WIDTH - 1)) - K'(1));
			lsat_c[l] = ovf_s[K][l] || (quot_s[K][l] > lim_c[l]);
			qv_c[l]   = lsat_c[l] ? lim_c[l] : quot_s[K][l];
			sv_c[l]   = flg_s[K].neg[l] ? (~qv_c[l] + K'(1)) : qv_c[l];
		end
	end

	always_ff @(posedge clk) begin
		if (en[S-1]) begin
			for (int l = 0; l < LANES; l++) begin
				res_s[l] <= flg_s[K].zero_norm ? '0 : sv_c[l][VEC_WIDTH-1:0];
			end
			zn_s  <= flg_s[K].zero_norm;
			sat_s <= !flg_s[K].zero_norm && (|lsat_c);
		end
	end

	assign out_valid = v[S-1];
	assign rotated_x = res_s[0];
	assign rotated_y = res_s[1];
	assign rotated_z = res_s[2];
	assign zero_norm = zn_s;
	assign saturated = sat_s;

endmodule

### hdl/quaternion_vector_rotate.sv
`timescale 1ns / 1ps
// Rotates a signed vector by a Q1.14 quaternion q, returning the vector part of
// q*v*conj(q) divided by |q|^2, rounded to nearest (ties away from zero) and
// saturated; the quaternion need not be unit length. A zero quaternion gives a
// zero vector with zero_norm set. Fully pipelined: one beat in and one out per
// cycle while out_ready stays high, through five product and sum stages
// followed by a restoring divider with one quotient bit per stage. Backpressure
// stalls only the stages that hold data.
module quaternion_vector_rotate #(
	parameter int VEC_WIDTH = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [qvr_pkg::QUAT_WIDTH-1:0] quat_w,
	input  logic signed [qvr_pkg::QUAT_WIDTH-1:0] quat_x,
	input  logic signed [qvr_pkg::QUAT_WIDTH-1:0] quat_y,
	input  logic signed [qvr_pkg::QUAT_WIDTH-1:0] quat_z,
	input  logic signed [VEC_WIDTH-1:0]           vec_x,
	input  logic signed [VEC_WIDTH-1:0]           vec_y,
	input  logic signed [VEC_WIDTH-1:0]           vec_z,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [VEC_WIDTH-1:0]           rotated_x,
	output logic signed [VEC_WIDTH-1:0]           rotated_y,
	output logic signed [VEC_WIDTH-1:0]           rotated_z,
	output logic                                  zero_norm,
	output logic                                  saturated
);
	import qvr_pkg::*;

	localparam int NW = VEC_WIDTH + 2 * QUAT_WIDTH + 5;

	logic                mid_valid, mid_ready;
	logic [NW-1:0]       num_x, num_y, num_z;
	logic [NORM_WIDTH:0] den;
	qvr_flags_t          flags;

	// Products, sums and dividend setup.
	qvr_front #(.VEC_WIDTH(VEC_WIDTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.quat_w    (quat_w),
		.quat_x    (quat_x),
		.quat_y    (quat_y),
		.quat_z    (quat_z),
		.vec_x     (vec_x),
		.vec_y     (vec_y),
		.vec_z     (vec_z),
		.out_valid (mid_valid),
		.out_ready (mid_ready),
		.num_x     (num_x),
		.num_y     (num_y),
		.num_z     (num_z),
		.den       (den),
		.flags     (flags)
	);

	// Division by the squared norm and saturation.
	qvr_div #(.VEC_WIDTH(VEC_WIDTH)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mid_valid),
		.in_ready  (mid_ready),
		.num_x     (num_x),
		.num_y     (num_y),
		.num_z     (num_z),
		.den       (den),
		.flags     (flags),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.rotated_x (rotated_x),
		.rotated_y (rotated_y),
		.rotated_z (rotated_z),
		.zero_norm (zero_norm),
		.saturated (saturated)
	);

endmodule

### hdl/qvr_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module qvr_checker #(
	parameter int VEC_WIDTH = 16
) (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  in_valid,
	input logic                                  in_ready,
	input logic signed [qvr_pkg::QUAT_WIDTH-1:0] quat_w,
	input logic signed [qvr_pkg::QUAT_WIDTH-1:0] quat_x,
	input logic signed [qvr_pkg::QUAT_WIDTH-1:0] quat_y,
	input logic signed [qvr_pkg::QUAT_WIDTH-1:0] quat_z,
	input logic signed [VEC_WIDTH-1:0]           vec_x,
	input logic signed [VEC_WIDTH-1:0]           vec_y,
	input logic signed [VEC_WIDTH-1:0]           vec_z,
	input logic                                  out_valid,
	input logic                                  out_ready,
	input logic signed [VEC_WIDTH-1:0]           rotated_x,
	input logic signed [VEC_WIDTH-1:0]           rotated_y,
	input logic signed [VEC_WIDTH-1:0]           rotated_z,
	input logic                                  zero_norm,
	input logic                                  saturated
);
	localparam logic [VEC_WIDTH-1:0] VMAX = {1'b0, {(VEC_WIDTH-1){1'b1}}};
	localparam logic [VEC_WIDTH-1:0] VMIN = {1'b1, {(VEC_WIDTH-1){1'b0}}};

	// Hold a stalled result beat.
	`QVR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(rotated_x) && $stable(rotated_y) && $stable(rotated_z) && $stable(zero_norm) && $stable(saturated))

	// Drop the vector for a zero quaternion.
	`QVR_ASSERT_SAME(a_zero_vec, out_valid && zero_norm, rotated_x == '0 && rotated_y == '0 && rotated_z == '0)

	// Never flag clipping on a zero quaternion.
	`QVR_ASSERT_SAME(a_zero_nosat, out_valid && zero_norm, !saturated)

	// Clipping leaves at least one component at a rail.
	`QVR_ASSERT_SAME(a_sat_rail, out_valid && saturated, rotated_x == VMAX || rotated_x == VMIN || rotated_y == VMAX || rotated_y == VMIN || rotated_z == VMAX || rotated_z == VMIN)

endmodule

bind quaternion_vector_rotate qvr_checker #(.VEC_WIDTH(VEC_WIDTH)) u_qvr_checker (.*);

### tb/sv/tb_quaternion_vector_rotate.sv
`timescale 1ns / 1ps
module tb_quaternion_vector_rotate;
	import qvr_pkg::*;

	localparam int VW        = 16;
	localparam int LATENCY   = VW + 8;
	localparam int IDLE_MAX  = 2000;
	localparam int LONG_HOLD = 4 * LATENCY;
	localparam int N_RANDOM  = 400;

	typedef logic signed [QUAT_WIDTH-1:0] qcomp_t;
	typedef logic signed [VW-1:0]         vcomp_t;

	typedef struct {
		qcomp_t w, x, y, z;
		vcomp_t a, b, c;
	} pose_beat_t;

	typedef struct {
		vcomp_t rx, ry, rz;
		logic   zero_norm;
		logic   saturated;
	} rotated_beat_t;

	// Track rotated vectors still owed by the block.
	class rotation_scoreboard;
		rotated_beat_t pending_rot[$];

		// Divide with round half away from zero, then clip to the vector range.
		function automatic vcomp_t div_round_clip(longint num, longint den, ref bit clipped);
			longint mag, quo, rem, lim;
			bit     neg;
			neg = num < 0;
			mag = neg ? -num : num;
			quo = mag / den;
			rem = mag % den;
			if (rem >= den - rem)
				quo++;
			lim = neg ? (64'sd1 << (VW - 1)) : ((64'sd1 << (VW - 1)) - 1);
			if (quo > lim) begin
				clipped = 1'b1;
				quo = lim;
			end
			return neg ? vcomp_t'(-quo) : vcomp_t'(quo);
		endfunction

		// Vector part of q*v*conj(q) over the squared norm.
		function automatic rotated_beat_t rotate(pose_beat_t p);
			longint        w, x, y, z, a, b, c, nrm, m0, m1, m2, m3, ax, ay, az;
			bit            clipped;
			rotated_beat_t r;
			w = p.w; x = p.x; y = p.y; z = p.z;
			a = p.a; b = p.b; c = p.c;
			nrm = w * w + x * x + y * y + z * z;
			clipped = 1'b0;
			r.zero_norm = 1'b0;
			if (nrm == 0) begin
				r.rx = '0; r.ry = '0; r.rz = '0;
				r.zero_norm = 1'b1;
				r.saturated = 1'b0;
				return r;
			end
			m0 = a * x + b * y + c * z;
			m1 = a * w - b * z + c * y;
			m2 = a * z + b * w - c * x;
			m3 = -a * y + b * x + c * w;
			ax = w * m1 + x * m0 + y * m3 - z * m2;
			ay = w * m2 - x * m3 + y * m0 + z * m1;
			az = w * m3 + x * m2 - y * m1 + z * m0;
			r.rx = div_round_clip(ax, nrm, clipped);
			r.ry = div_round_clip(ay, nrm, clipped);
			r.rz = div_round_clip(az, nrm, clipped);
			r.saturated = clipped;
			return r;
		endfunction

		function void note_pose(pose_beat_t p);
			pending_rot.push_back(rotate(p));
		endfunction

		// Return a description of every mismatching field, empty when clean.
		function string check_rotated(rotated_beat_t got);
			rotated_beat_t exp_r;
			string         msg;
			if (pending_rot.size() == 0)
				return "result beat with nothing pending";
			exp_r = pending_rot.pop_front();
			msg = "";
			if (got.rx !== exp_r.rx)
				msg = {msg, $sformatf(" rotated_x %0d/%0d", got.rx, exp_r.rx)};
			if (got.ry !== exp_r.ry)
				msg = {msg, $sformatf(" rotated_y %0d/%0d", got.ry, exp_r.ry)};
			if (got.rz !== exp_r.rz)
				msg = {msg, $sformatf(" rotated_z %0d/%0d", got.rz, exp_r.rz)};
			if (got.zero_norm !== exp_r.zero_norm)
				msg = {msg, $sformatf(" zero_norm %b/%b", got.zero_norm, exp_r.zero_norm)};
			if (got.saturated !== exp_r.saturated)
				msg = {msg, $sformatf(" saturated %b/%b", got.saturated, exp_r.saturated)};
			return msg;
		endfunction
	endclass

	logic   clk;
	logic   arst_n;
	logic   in_valid;
	logic   in_ready;
	qcomp_t quat_w, quat_x, quat_y, quat_z;
	vcomp_t vec_x, vec_y, vec_z;
	logic   out_valid;
	logic   out_ready;
	vcomp_t rotated_x, rotated_y, rotated_z;
	logic   zero_norm;
	logic   saturated;

	rotation_scoreboard sb = new();
	int  mismatch_cnt;
	int  idle_cycles;
	bit  quiet;
	bit  long_hold_req;

	quaternion_vector_rotate #(.VEC_WIDTH(VW)) uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
		.vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.rotated_x(rotated_x), .rotated_y(rotated_y), .rotated_z(rotated_z),
		.zero_norm(zero_norm), .saturated(saturated)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	task automatic report(string msg);
		$display("mismatch at %0t:%s", $realtime, msg);
		mismatch_cnt++;
	endtask

	// Note accepted input beats and check accepted result beats.
	always @(posedge clk) begin
		rotated_beat_t got;
		string         msg;
		if (arst_n && in_valid && in_ready)
			sb.note_pose('{quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z});
		if (arst_n && out_valid && out_ready) begin
			got = '{rotated_x, rotated_y, rotated_z, zero_norm, saturated};
			msg = sb.check_rotated(got);
			if (msg != "")
				report(msg);
		end
	end

	// End the run when nothing moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else if (idle_cycles >= IDLE_MAX) begin
			$display("simulation failed");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	// Drive out_ready: short random stalls, one long hold on request.
	initial begin
		int hold_cnt;
		hold_cnt = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_req && hold_cnt == 0) begin
				long_hold_req = 1'b0;
				hold_cnt = LONG_HOLD;
			end
			if (hold_cnt > 0) begin
				out_ready <= 1'b0;
				hold_cnt--;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				hold_cnt = $urandom_range(1, 4) - 1;
			end else
				out_ready <= 1'b1;
		end
	end

	// Offer one beat, with an optional idle burst first, and hold until taken.
	task automatic send_pose(pose_beat_t p);
		int gap;
		gap = (!quiet && $urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		quat_w <= p.w; quat_x <= p.x; quat_y <= p.y; quat_z <= p.z;
		vec_x <= p.a; vec_y <= p.b; vec_z <= p.c;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain;
		while (sb.pending_rot.size() != 0)
			@(posedge clk);
	endtask

	function automatic pose_beat_t random_pose();
		pose_beat_t p;
		int         kind;
		kind = $urandom_range(0, 9);
		p.a = vcomp_t'($urandom); p.b = vcomp_t'($urandom); p.c = vcomp_t'($urandom);
		if (kind < 3) begin
			p.w = qcomp_t'($urandom); p.x = qcomp_t'($urandom);
			p.y = qcomp_t'($urandom); p.z = qcomp_t'($urandom);
		end else if (kind == 3) begin
			p.w = '0; p.x = '0; p.y = '0; p.z = '0;
		end else begin
			// quaternion components within +-1.0 in Q1.14
			p.w = qcomp_t'(int'($urandom_range(0, 32768)) - 16384);
			p.x = qcomp_t'(int'($urandom_range(0, 32768)) - 16384);
			p.y = qcomp_t'(int'($urandom_range(0, 32768)) - 16384);
			p.z = qcomp_t'(int'($urandom_range(0, 32768)) - 16384);
			if (kind == 9) begin
				p.a = vcomp_t'(int'($urandom_range(0, 200)) - 100);
				p.b = vcomp_t'(int'($urandom_range(0, 200)) - 100);
				p.c = vcomp_t'(int'($urandom_range(0, 200)) - 100);
			end
		end
		return p;
	endfunction

	initial begin
		pose_beat_t directed[$];
		arst_n = 1'b0;
		in_valid = 1'b0;
		quat_w = '0; quat_x = '0; quat_y = '0; quat_z = '0;
		vec_x = '0; vec_y = '0; vec_z = '0;
		quiet = 1'b0;
		long_hold_req = 1'b0;
		mismatch_cnt = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero quaternion, identity, unnormalized, extremes, rounding, clipping
		directed.push_back('{0, 0, 0, 0, 1000, -2000, 3000});
		directed.push_back('{0, 0, 0, 0, 32767, -32768, -1});
		directed.push_back('{16384, 0, 0, 0, 32767, -32768, 12345});
		directed.push_back('{1, 0, 0, 0, -32768, 32767, 0});
		directed.push_back('{-32768, 0, 0, 0, 100, 200, 300});
		directed.push_back('{0, 16384, 0, 0, 1, 2, 3});
		directed.push_back('{0, 0, 16384, 0, 1, 2, 3});
		directed.push_back('{0, 0, 0, 16384, 1, 2, 3});
		directed.push_back('{11585, 0, 0, 11585, 1000, 0, 0});
		directed.push_back('{11585, 0, 0, 11585, 32767, 32767, 0});
		directed.push_back('{11585, 0, 0, -11585, -32768, -32768, 0});
		directed.push_back('{-32768, -32768, -32768, -32768, -32768, -32768, -32768});
		directed.push_back('{32767, 32767, 32767, 32767, 32767, 32767, 32767});
		directed.push_back('{32767, -32768, 32767, -32768, 32767, -32768, 32767});
		directed.push_back('{3, 1, 1, 1, 1, 0, 0});
		directed.push_back('{1, 1, 0, 0, 1, 1, 1});
		directed.push_back('{1, 1, 1, 0, 3, 5, -7});
		directed.push_back('{0, 1, 0, 0, -32768, 32767, -32768});
		directed.push_back('{9459, 9459, 9459, 0, 32767, -32768, 32767});
		directed.push_back('{-1, -1, -1, -1, -1, -1, -1});
		foreach (directed[i])
			send_pose(directed[i]);

		// pause until the pipeline is empty
		in_valid <= 1'b0;
		drain();

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM / 4)
				long_hold_req = 1'b1;
			if (i == N_RANDOM - 60)
				quiet = 1'b1;
			send_pose(random_pose());
		end
		in_valid <= 1'b0;

		drain();
		repeat (LATENCY + 8) @(posedge clk);
		if (sb.pending_rot.size() != 0)
			report(" result beats missing at end");
		if (mismatch_cnt == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

### sim.f
+incdir+hdl
hdl/qvr_pkg.sv
hdl/qvr_front.sv
hdl/qvr_div.sv
hdl/quaternion_vector_rotate.sv
hdl/qvr_checker.sv
tb/sv/tb_quaternion_vector_rotate.sv
